// ===== design/assert_macros.svh =====
// Assertion macros used by the top level of the join engine RTL.
// No dependencies; ASSERT_OFF turns every check into nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/nlej_pkg.sv =====
// Package of the nested loop equi-join engine: widths, codes and item types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package nlej_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int KEY_W = 32;
    localparam int PL_W = 32;
    localparam int KIND_W = 2;
    localparam int IN_DATA_W = KEY_W + PL_W;
    localparam int OUT_DATA_W = KEY_W + 2 * PL_W;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PROBE = 1'b1;

    localparam logic [KIND_W-1:0] KIND_STORED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MATCH = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NOMATCH = 2'd3;

    typedef struct packed {
        logic                    is_probe;
        logic signed [KEY_W-1:0] key;
        logic [PL_W-1:0]         payload;
    } nlej_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [KEY_W-1:0] key;
        logic [PL_W-1:0]         probe_pl;
        logic [PL_W-1:0]         build_pl;
        logic                    last;
    } nlej_result_t;

endpackage

// ===== design/nested_loop_equi_join.sv =====
// Top level of the nested loop equi-join engine.
// Instantiates nlej_front and nlej_back; uses nlej_pkg and assert_macros.svh.
//
// Input beats on the s_axis channel carry a key and payload in tdata and the
// operation in tuser: a load appends a build record to the table if it has
// room, a probe looks its key up in every stored record, oldest first.
// Result beats leave on the m_axis channel with the result kind in tuser and
// tlast set on the final result of each input beat.
// A load answers with one beat, registered once the back end takes it from
// the queue, and the back end can take a load every cycle while the output
// is free. A probe holds the back end while it is taken from the queue,
// while each stored entry is read in turn through the single read port,
// while the last entry is compared and while the final result is sent;
// against an empty table only the first and the last of these steps remain.
// A two-entry queue lets input beats be taken while a probe is scanning.
// Reset empties the table and the queue and drops any pending result.
// When the receiver stalls, the result register holds its beat, a scan
// halts at a match while another is held; a full queue drops s_axis_tready.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nested_loop_equi_join
    import nlej_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // key, payload
    input  logic                  s_axis_tuser,   // op
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // key_out, probe_payload, build_payload
    output logic [KIND_W-1:0]     m_axis_tuser,   // kind
    output logic                  m_axis_tlast
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    nlej_item_t    q_item;
    logic          q_valid;
    logic          q_ready;
    logic [CW-1:0] entry_count;

    nlej_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_item        (q_item),
        .q_valid       (q_valid),
        .q_ready       (q_ready)
    );

    nlej_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_item        (q_item),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .entry_count   (entry_count)
    );

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, entry_count <= CW'(TABLE_DEPTH))
    `ASSERT_ALWAYS(a_count_step, clk, rst_n, (entry_count == $past(entry_count)) || (entry_count == $past(entry_count) + 1'b1))
    `ASSERT_ALWAYS(a_stall_has_work, clk, rst_n, s_axis_tready || q_valid)
    `ASSERT_NEXT(a_load_answers, clk, rst_n, q_valid && q_ready && !q_item.is_probe, m_axis_tvalid)

endmodule

// ===== design/nlej_front.sv =====
// Front end of the join engine: takes input beats, classifies them as load
// or probe and keeps them in a short queue for the back end. Uses nlej_pkg.
`timescale 1ns / 1ps
module nlej_front
    import nlej_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,  // key, payload
    input  logic                 s_axis_tuser,  // op
    output nlej_item_t           q_item,
    output logic                 q_valid,
    input  logic                 q_ready
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    nlej_item_t        item_mem_reg [QUEUE_DEPTH];
    logic [QW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0]     fill_reg, fill_next;
    nlej_item_t        in_item;
    logic              push;
    logic              pop;

    always_comb
    begin
        in_item.is_probe = (s_axis_tuser == OP_PROBE);
        in_item.key = s_axis_tdata[KEY_W-1:0];
        in_item.payload = s_axis_tdata[IN_DATA_W-1:KEY_W];
    end

    assign s_axis_tready = (fill_reg != FW'(QUEUE_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_item = item_mem_reg[rd_ptr_reg];
    assign push = s_axis_tvalid && s_axis_tready;
    assign pop = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== design/nlej_back.sv =====
// Back end of the join engine: stores build records in the table memory and
// scans it one entry per cycle for each probe while not stalled. Uses nlej_pkg.
`timescale 1ns / 1ps
module nlej_back
    import nlej_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  nlej_item_t                          q_item,
    input  logic                                q_valid,
    output logic                                q_ready,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [OUT_DATA_W-1:0]               m_axis_tdata,  // key_out, probe_payload, build_payload
    output logic [KIND_W-1:0]                   m_axis_tuser,  // kind
    output logic                                m_axis_tlast,
    output logic [$clog2(TABLE_DEPTH + 1)-1:0]  entry_count
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                    state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic signed [KEY_W-1:0] probe_key_reg, probe_key_next;
    logic [PL_W-1:0]         probe_pl_reg, probe_pl_next;
    logic [CW-1:0]           scan_idx_reg, scan_idx_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]           cmp_idx_reg, cmp_idx_next;
    logic                    hold_vld_reg, hold_vld_next;
    logic [PL_W-1:0]         hold_pl_reg, hold_pl_next;
    logic                    out_vld_reg, out_vld_next;
    nlej_result_t            out_reg, out_next;

    logic signed [KEY_W-1:0] key_mem [TABLE_DEPTH];
    logic [PL_W-1:0]         pl_mem [TABLE_DEPTH];
    logic signed [KEY_W-1:0] rd_key_reg;
    logic [PL_W-1:0]         rd_pl_reg;
    logic [IW-1:0]           rd_idx;
    logic                    mem_we;

    logic                    out_free;
    logic                    match;
    logic                    scan_done;
    logic                    advance;

    function automatic nlej_result_t make_result(
        input logic [KIND_W-1:0]       kind,
        input logic signed [KEY_W-1:0] key,
        input logic [PL_W-1:0]         probe_pl,
        input logic [PL_W-1:0]         build_pl,
        input logic                    last
    );
        nlej_result_t r;
        r.kind = kind;
        r.key = key;
        r.probe_pl = probe_pl;
        r.build_pl = build_pl;
        r.last = last;
        return r;
    endfunction

    assign out_free = !out_vld_reg || m_axis_tready;
    assign match = cmp_vld_reg && (rd_key_reg == probe_key_reg);
    assign scan_done = (scan_idx_reg == count_reg) && !cmp_vld_reg;
    assign advance = !match || !hold_vld_reg || out_free;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        probe_key_next = probe_key_reg;
        probe_pl_next = probe_pl_reg;
        scan_idx_next = scan_idx_reg;
        cmp_vld_next = cmp_vld_reg;
        cmp_idx_next = cmp_idx_reg;
        hold_vld_next = hold_vld_reg;
        hold_pl_next = hold_pl_reg;
        out_vld_next = out_vld_reg && !m_axis_tready;
        out_next = out_reg;
        q_ready = 1'b0;
        mem_we = 1'b0;
        rd_idx = cmp_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_item.is_probe)
                begin
                    q_ready = 1'b1;
                    probe_key_next = q_item.key;
                    probe_pl_next = q_item.payload;
                    scan_idx_next = '0;
                    cmp_vld_next = 1'b0;
                    hold_vld_next = 1'b0;
                    state_next = ST_SCAN;
                end
                else if (q_valid && out_free)
                begin
                    q_ready = 1'b1;
                    out_vld_next = 1'b1;
                    if (count_reg < CW'(TABLE_DEPTH))
                    begin
                        mem_we = 1'b1;
                        count_next = count_reg + 1'b1;
                        out_next = make_result(KIND_STORED, q_item.key, '0, '0, 1'b1);
                    end
                    else
                    begin
                        out_next = make_result(KIND_FULL, q_item.key, '0, '0, 1'b1);
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    if (out_free)
                    begin
                        out_vld_next = 1'b1;
                        if (hold_vld_reg)
                        begin
                            out_next = make_result(KIND_MATCH, probe_key_reg, probe_pl_reg,
                                                   hold_pl_reg, 1'b1);
                        end
                        else
                        begin
                            out_next = make_result(KIND_NOMATCH, probe_key_reg, probe_pl_reg,
                                                   '0, 1'b1);
                        end
                        hold_vld_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
                else if (advance)
                begin
                    rd_idx = scan_idx_reg[IW-1:0];
                    if (scan_idx_reg < count_reg)
                    begin
                        cmp_vld_next = 1'b1;
                        cmp_idx_next = scan_idx_reg[IW-1:0];
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                    else
                    begin
                        cmp_vld_next = 1'b0;
                    end
                    if (match)
                    begin
                        if (hold_vld_reg)
                        begin
                            out_vld_next = 1'b1;
                            out_next = make_result(KIND_MATCH, probe_key_reg, probe_pl_reg,
                                                   hold_pl_reg, 1'b0);
                        end
                        hold_vld_next = 1'b1;
                        hold_pl_next = rd_pl_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            scan_idx_reg <= '0;
            cmp_vld_reg <= 1'b0;
            hold_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_idx_reg <= scan_idx_next;
            cmp_vld_reg <= cmp_vld_next;
            hold_vld_reg <= hold_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_key_reg <= probe_key_next;
        probe_pl_reg <= probe_pl_next;
        cmp_idx_reg <= cmp_idx_next;
        hold_pl_reg <= hold_pl_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[count_reg[IW-1:0]] <= q_item.key;
            pl_mem[count_reg[IW-1:0]] <= q_item.payload;
        end
        rd_key_reg <= key_mem[rd_idx];
        rd_pl_reg <= pl_mem[rd_idx];
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata = {out_reg.build_pl, out_reg.probe_pl, out_reg.key};
    assign m_axis_tuser = out_reg.kind;
    assign m_axis_tlast = out_reg.last;
    assign entry_count = count_reg;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the nested loop equi-join engine: directed table, then random loads
// and probes, each result beat compared with a typed row's kind or a predictor of the join table.
// Depends on nlej_pkg and the nested_loop_equi_join RTL only.
`timescale 1ns / 1ps
module testbench;
    import nlej_pkg::*;

    localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 291;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 150;
    localparam int NUM_ROWS = 19;

    typedef struct packed {
        logic              op;
        logic [KEY_W-1:0]  key;
        logic [PL_W-1:0]   pl;
        logic              typed;
        logic [KIND_W-1:0] kind;
    } stim_row_t;

    typedef enum logic [1:0] {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]     m_axis_tuser;
    logic                  m_axis_tlast;

    logic [KEY_W-1:0] build_key_tbl [TABLE_DEPTH];
    logic [PL_W-1:0]  build_pl_tbl [TABLE_DEPTH];
    int               stored_cnt;

    nlej_result_t pending_results [$];
    nlej_result_t join_out [$];
    nlej_result_t seen_res;
    nlej_result_t want_res;

    stim_row_t        directed_rows [NUM_ROWS];
    logic [KEY_W-1:0] key_pool [8];
    int               error_count;
    int               idle_cycles;
    int               burst_left;
    int               kind_seen [4];
    int               loads_sent;
    int               probes_sent;
    rx_mode_t         rx_mode;
    int               rx_stretch;

    nested_loop_equi_join dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void join_predict(input logic op, input logic [KEY_W-1:0] key,
                                         input logic [PL_W-1:0] pl);
        nlej_result_t r;
        join_out.delete();
        r.key = key;
        r.last = 1'b1;
        r.probe_pl = '0;
        r.build_pl = '0;
        if (op == OP_LOAD)
        begin
            if (stored_cnt >= TABLE_DEPTH)
            begin
                r.kind = KIND_FULL;
            end
            else
            begin
                build_key_tbl[stored_cnt] = key;
                build_pl_tbl[stored_cnt] = pl;
                stored_cnt++;
                r.kind = KIND_STORED;
            end
            join_out.push_back(r);
        end
        else
        begin
            r.probe_pl = pl;
            r.last = 1'b0;
            r.kind = KIND_MATCH;
            for (int i = 0; i < stored_cnt; i++)
            begin
                if (build_key_tbl[i] == key)
                begin
                    r.build_pl = build_pl_tbl[i];
                    join_out.push_back(r);
                end
            end
            if (join_out.size() == 0)
            begin
                r.kind = KIND_NOMATCH;
                r.build_pl = '0;
                join_out.push_back(r);
            end
            join_out[join_out.size()-1].last = 1'b1;
        end
    endfunction

    task automatic issue_item(input stim_row_t row);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 10);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(1, 16);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {row.pl, row.key};
        s_axis_tuser <= row.op;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        join_predict(row.op, row.key, row.pl);
        if (row.op == OP_LOAD)
            loads_sent++;
        else
            probes_sent++;
        if (row.typed)
        begin
            want_res.kind = row.kind;
            want_res.key = row.key;
            want_res.probe_pl = (row.op == OP_PROBE) ? row.pl : '0;
            want_res.build_pl = '0;
            want_res.last = 1'b1;
            pending_results.push_back(want_res);
        end
        else
        begin
            foreach (join_out[i]) pending_results.push_back(join_out[i]);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_res.kind = m_axis_tuser;
            seen_res.key = m_axis_tdata[KEY_W-1:0];
            seen_res.probe_pl = m_axis_tdata[KEY_W+PL_W-1:KEY_W];
            seen_res.build_pl = m_axis_tdata[OUT_DATA_W-1:KEY_W+PL_W];
            seen_res.last = m_axis_tlast;
            kind_seen[seen_res.kind]++;
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected: kind %0d key %h",
                       seen_res.kind, seen_res.key);
                error_count++;
            end
            else
            begin
                want_res = pending_results.pop_front();
                compare_field("kind", 32'(want_res.kind), 32'(seen_res.kind));
                compare_field("key_out", want_res.key, seen_res.key);
                compare_field("probe_payload", want_res.probe_pl, seen_res.probe_pl);
                compare_field("build_payload", want_res.build_pl, seen_res.build_pl);
                compare_field("last", 32'(want_res.last), 32'(seen_res.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_stretch = $urandom_range(20, 200);
            repeat (rx_stretch)
            begin
                @(negedge clk);
                case (rx_mode)
                    RX_FREE:   m_axis_tready <= 1'b1;
                    RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_axis_tready <= ~m_axis_tready;
                endcase
            end
        end
    end

    initial
    begin
        stim_row_t row;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_LOAD;
        stored_cnt = 0;
        error_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        loads_sent = 0;
        probes_sent = 0;
        foreach (kind_seen[i]) kind_seen[i] = 0;

        directed_rows = '{
            '{OP_PROBE, 32'h0000_0000, 32'h1234_5678, 1'b1, KIND_NOMATCH},
            '{OP_PROBE, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, KIND_NOMATCH},
            '{OP_LOAD,  32'h8000_0000, 32'h0000_0000, 1'b1, KIND_STORED},
            '{OP_LOAD,  32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, KIND_STORED},
            '{OP_LOAD,  32'h0000_0000, 32'hA5A5_A5A5, 1'b1, KIND_STORED},
            '{OP_LOAD,  32'hFFFF_FFFF, 32'h5A5A_5A5A, 1'b1, KIND_STORED},
            '{OP_LOAD,  32'h8000_0000, 32'h0000_0001, 1'b1, KIND_STORED},
            '{OP_PROBE, 32'h8000_0000, 32'hDEAD_BEEF, 1'b0, KIND_MATCH},
            '{OP_PROBE, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, KIND_MATCH},
            '{OP_PROBE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, KIND_MATCH},
            '{OP_PROBE, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, KIND_MATCH},
            '{OP_PROBE, 32'h0000_0001, 32'h0000_0001, 1'b1, KIND_NOMATCH},
            '{OP_PROBE, 32'h8000_0001, 32'h7FFF_FFFF, 1'b1, KIND_NOMATCH},
            '{OP_PROBE, 32'h7FFF_FFFE, 32'hFFFF_FFFE, 1'b1, KIND_NOMATCH},
            '{OP_LOAD,  32'h0000_0000, 32'hFFFF_0000, 1'b1, KIND_STORED},
            '{OP_LOAD,  32'h0000_0000, 32'h0000_FFFF, 1'b1, KIND_STORED},
            '{OP_PROBE, 32'h0000_0000, 32'h0F0F_0F0F, 1'b0, KIND_MATCH},
            '{OP_LOAD,  32'h8000_0000, 32'h7FFF_FFFF, 1'b1, KIND_STORED},
            '{OP_PROBE, 32'h8000_0000, 32'h0000_0000, 1'b0, KIND_MATCH}
        };

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 8; i++) key_pool[i] = $urandom();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) issue_item(directed_rows[i]);

        // Loads dominate until the table fills; after that only a few loads, which
        // must be dropped. Most keys come from a small pool so that probes find
        // many matches.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (stored_cnt < TABLE_DEPTH)
                row.op = ($urandom_range(0, 99) < 55) ? OP_LOAD : OP_PROBE;
            else
                row.op = ($urandom_range(0, 99) < 10) ? OP_LOAD : OP_PROBE;
            row.key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 7)]
                                                 : $urandom();
            row.pl = $urandom();
            row.typed = 1'b0;
            row.kind = KIND_STORED;
            issue_item(row);
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d loads and %0d probes, table filled to %0d entries",
                 loads_sent, probes_sent, stored_cnt);
        $display("results seen: %0d stored, %0d dropped, %0d matches, %0d without match",
                 kind_seen[KIND_STORED], kind_seen[KIND_FULL], kind_seen[KIND_MATCH],
                 kind_seen[KIND_NOMATCH]);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/nlej_pkg.sv
design/nlej_front.sv
design/nlej_back.sv
design/nested_loop_equi_join.sv
tb/testbench.sv
